@@ rtl/indexed_min_heap_queue_unit_assert.svh @@
// Assertion macros shared by the indexed heap queue RTL.
// No dependencies.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define IMHQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imhq check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define IMHQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imhq check failed");
`endif

@@ rtl/imhq_pkg.sv @@
// Package for the indexed heap queue: payload types, codes, states.
// No dependencies.
package imhq_pkg;
  localparam int NODES_DEF = 256;
  localparam int KEY_BITS_DEF = 32;
  localparam int NODE_W = 8;
  localparam int KEY_IN_W = 32;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CHANGE = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL = 3'd2,
    ST_DUP = 3'd3,
    ST_ABSENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [NODE_W-1:0] node_id;
    logic [KEY_IN_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] min_node;
    logic [2:0] status;
    logic [COUNT_W-1:0] count;
    logic is_empty;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_UP_RD,
    S_UP_KEY,
    S_UP_CMP,
    S_UP_WR,
    S_DN_RD0,
    S_DN_RD1,
    S_DN_RD2,
    S_DN_CMP,
    S_DN_WR,
    S_EX_RD,
    S_EX_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic lt;
  } cmp_res_t;
endpackage

@@ rtl/imhq_key_cmp.sv @@
// Shared key comparator for the heap sequencer.
// Depends on imhq_pkg.
module imhq_key_cmp #(
  parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  output imhq_pkg::cmp_res_t  res
);
  import imhq_pkg::*;
  always_comb begin
    res.lt = (a < b);
  end
endmodule

@@ rtl/indexed_min_heap_queue_unit.sv @@
// Top level of the indexed min-heap queue: sequencer, stores, result register.
// Depends on imhq_pkg, imhq_key_cmp and the assertion header.
//
//  channel | direction | payload
//  in_     | input     | in_item_t (opcode, node_id, key)
//  out_    | output    | out_item_t (min_node, status, count, is_empty)
//
// An item is handled step by step: sift up reads, compares and moves per
// level climbed, sift down reads and compares both children per level visited,
// paced by the one read port of each memory and the shared comparator. Reset
// clears the node map entry by entry, during which in_ready stays low. The
// result waits in an output register; a new item is taken only once it has left.
`include "indexed_min_heap_queue_unit_assert.svh"
module indexed_min_heap_queue_unit #(
  parameter int NODES = imhq_pkg::NODES_DEF,
  parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  imhq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output imhq_pkg::out_item_t  out_data
);
  import imhq_pkg::*;
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PW = AW + 1;

  logic [AW-1:0] hs_mem [NODES];
  logic [PW-1:0] son_mem [NODES];
  logic [KEY_BITS-1:0] key_mem [NODES];

  state_t state_r, state_nxt;
  logic clr_r;
  logic [PW-1:0] clr_cnt_r;
  logic [PW-1:0] cnt_r, cnt_nxt;
  in_item_t item_r;
  logic [AW-1:0] node_r, node_nxt;
  logic [KEY_BITS-1:0] nkey_r, nkey_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] pn_r, pn_nxt;
  logic [AW-1:0] ln_r, ln_nxt, rn_r, rn_nxt;
  logic [KEY_BITS-1:0] lk_r, lk_nxt;
  logic [PW-1:0] best_r, best_nxt;
  logic [2:0] status_r, status_nxt;
  logic [NODE_W-1:0] minn_r, minn_nxt;
  logic ov_r;
  out_item_t od_r;

  logic [AW-1:0] hs_ra;
  logic [AW-1:0] hs_rd_r;
  logic [AW-1:0] son_ra;
  logic [PW-1:0] son_rd_r;
  logic [AW-1:0] key_ra;
  logic [KEY_BITS-1:0] key_rd_r;
  logic hs_we, son_we;
  logic [AW-1:0] hs_wa, son_wa;
  logic [AW-1:0] hs_wd;
  logic [PW-1:0] son_wd;
  logic key_we;

  logic [KEY_BITS-1:0] ca, cb;
  cmp_res_t cres;
  logic node_ok;
  logic [AW-1:0] in_node;
  logic [PW:0] lpos, rpos;
  logic [PW-1:0] parent;

  imhq_key_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (.a(ca), .b(cb), .res(cres));

  assign node_ok = ({24'd0, item_r.node_id} < 32'(NODES));
  assign in_node = node_ok ? AW'(item_r.node_id) : '0;
  assign lpos = {pos_r, 1'b1};
  assign rpos = {pos_r, 1'b0} + (PW+1)'(2);
  assign parent = (pos_r - PW'(1)) >> 1;

  assign in_ready = (state_r == S_IDLE) && !clr_r && !ov_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    hs_rd_r <= hs_mem[hs_ra];
    if (son_we) son_mem[son_wa] <= son_wd;
    son_rd_r <= son_mem[son_ra];
    if (key_we) key_mem[node_r] <= nkey_r;
    key_rd_r <= key_mem[key_ra];
  end

  // Read addresses and comparator operands.
  always_comb begin
    hs_ra = '0;
    son_ra = AW'(in_data.node_id);
    key_ra = '0;
    ca = nkey_r;
    cb = key_rd_r;
    case (state_r)
      S_UP_RD: begin
        hs_ra = parent[AW-1:0];
      end
      S_UP_KEY: begin
        key_ra = hs_rd_r;
      end
      S_UP_CMP: begin
        ca = nkey_r;
        cb = key_rd_r;
      end
      S_EX_RD: begin
        hs_ra = cnt_r[AW-1:0];
      end
      S_DN_RD0: begin
        hs_ra = lpos[AW-1:0];
        key_ra = node_r;
      end
      S_DN_RD1: begin
        hs_ra = rpos[AW-1:0];
        key_ra = hs_rd_r;
      end
      S_DN_RD2: begin
        key_ra = hs_rd_r;
        ca = key_rd_r;
        cb = nkey_r;
      end
      S_DN_CMP: begin
        ca = key_rd_r;
        cb = (best_r == pos_r) ? nkey_r : lk_r;
      end
      default: begin
        hs_ra = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid && in_ready) state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = S_DONE;
        if (item_r.opcode == OP_INSERT) begin
          if (!(node_ok && son_rd_r[PW-1]) && node_ok && ({1'b0, cnt_r} < (PW+1)'(NODES)))
            state_nxt = S_UP_RD;
        end else if (item_r.opcode == OP_EXTRACT) begin
          if (cnt_r != '0) state_nxt = S_EX_RD;
        end else if (item_r.opcode == OP_CHANGE) begin
          if (node_ok && son_rd_r[PW-1]) state_nxt = S_UP_RD;
        end
      end
      S_UP_RD:  state_nxt = (pos_r == '0) ? S_UP_WR : S_UP_KEY;
      S_UP_KEY: state_nxt = S_UP_CMP;
      S_UP_CMP: state_nxt = cres.lt ? S_UP_RD : S_UP_WR;
      S_UP_WR:  state_nxt = (item_r.opcode == OP_CHANGE) ? S_DN_RD0 : S_DONE;
      S_EX_RD:  state_nxt = S_EX_WR;
      S_EX_WR:  state_nxt = (cnt_r == '0) ? S_DONE : S_DN_RD0;
      S_DN_RD0: state_nxt = (lpos < {1'b0, cnt_r}) ? S_DN_RD1 : S_DN_WR;
      S_DN_RD1: state_nxt = S_DN_RD2;
      S_DN_RD2: state_nxt = (rpos < {1'b0, cnt_r}) ? S_DN_CMP : S_DN_WR;
      S_DN_CMP: state_nxt = S_DN_WR;
      S_DN_WR:  state_nxt = (best_r == pos_r) ? S_DONE : S_DN_RD0;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and memory writes.
  always_comb begin
    cnt_nxt = cnt_r;
    node_nxt = node_r;
    nkey_nxt = nkey_r;
    pos_nxt = pos_r;
    pn_nxt = pn_r;
    ln_nxt = ln_r;
    rn_nxt = rn_r;
    lk_nxt = lk_r;
    best_nxt = best_r;
    status_nxt = status_r;
    minn_nxt = minn_r;
    hs_we = 1'b0;
    hs_wa = '0;
    hs_wd = '0;
    son_we = 1'b0;
    son_wa = '0;
    son_wd = '0;
    key_we = 1'b0;
    case (state_r)
      S_CHK: begin
        status_nxt = ST_OK;
        minn_nxt = '0;
        node_nxt = in_node;
        nkey_nxt = KEY_BITS'(item_r.key);
        if (item_r.opcode == OP_INSERT) begin
          if (node_ok && son_rd_r[PW-1]) status_nxt = ST_DUP;
          else if (!node_ok || ({1'b0, cnt_r} >= (PW+1)'(NODES))) status_nxt = ST_FULL;
          else begin
            pos_nxt = cnt_r;
            cnt_nxt = cnt_r + PW'(1);
          end
        end else if (item_r.opcode == OP_EXTRACT) begin
          if (cnt_r == '0) status_nxt = ST_EMPTY;
          else cnt_nxt = cnt_r - PW'(1);
        end else if (item_r.opcode == OP_CHANGE) begin
          if (!(node_ok && son_rd_r[PW-1])) status_nxt = ST_ABSENT;
          else pos_nxt = {1'b0, son_rd_r[PW-2:0]};
        end
      end
      S_UP_RD: begin
        key_we = 1'b1;
      end
      S_UP_KEY: begin
        pn_nxt = hs_rd_r;
      end
      S_UP_CMP: begin
        if (cres.lt) begin
          hs_we = 1'b1;
          hs_wa = pos_r[AW-1:0];
          hs_wd = pn_r;
          son_we = 1'b1;
          son_wa = pn_r;
          son_wd = {1'b1, pos_r[PW-2:0]};
          pos_nxt = parent;
        end
      end
      S_UP_WR: begin
        hs_we = 1'b1;
        hs_wa = pos_r[AW-1:0];
        hs_wd = node_r;
        son_we = 1'b1;
        son_wa = node_r;
        son_wd = {1'b1, pos_r[PW-2:0]};
      end
      S_EX_RD: begin
        minn_nxt = NODE_W'(hs_rd_r);
        son_we = 1'b1;
        son_wa = hs_rd_r;
        son_wd = '0;
      end
      S_EX_WR: begin
        node_nxt = hs_rd_r;
        pos_nxt = '0;
      end
      S_DN_RD0: begin
        best_nxt = pos_r;
      end
      S_DN_RD1: begin
        ln_nxt = hs_rd_r;
        nkey_nxt = key_rd_r;
      end
      S_DN_RD2: begin
        lk_nxt = key_rd_r;
        rn_nxt = hs_rd_r;
        best_nxt = cres.lt ? PW'(lpos) : pos_r;
      end
      S_DN_CMP: begin
        if (cres.lt) begin
          best_nxt = PW'(rpos);
          ln_nxt = rn_r;
          lk_nxt = key_rd_r;
        end
      end
      S_DN_WR: begin
        if (best_r == pos_r) begin
          hs_we = 1'b1;
          hs_wa = pos_r[AW-1:0];
          hs_wd = node_r;
          son_we = 1'b1;
          son_wa = node_r;
          son_wd = {1'b1, pos_r[PW-2:0]};
        end else begin
          hs_we = 1'b1;
          hs_wa = pos_r[AW-1:0];
          hs_wd = ln_r;
          son_we = 1'b1;
          son_wa = ln_r;
          son_wd = {1'b1, pos_r[PW-2:0]};
          pos_nxt = best_r;
        end
      end
      default: begin
        hs_we = 1'b0;
      end
    endcase
    if (clr_r) begin
      son_we = 1'b1;
      son_wa = clr_cnt_r[AW-1:0];
      son_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + PW'(1);
        if (clr_cnt_r == PW'(NODES - 1)) clr_r <= 1'b0;
      end
      if (state_r == S_DONE) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    node_r <= node_nxt;
    nkey_r <= nkey_nxt;
    pos_r <= pos_nxt;
    pn_r <= pn_nxt;
    ln_r <= ln_nxt;
    rn_r <= rn_nxt;
    lk_r <= lk_nxt;
    best_r <= best_nxt;
    status_r <= status_nxt;
    minn_r <= minn_nxt;
    if (state_r == S_DONE) begin
      od_r.min_node <= minn_r;
      od_r.status <= status_r;
      od_r.count <= COUNT_W'(cnt_r);
      od_r.is_empty <= (cnt_r == '0);
    end
  end

  `IMHQ_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE && !ov_r)
  `IMHQ_ASSERT_IMP(a_count_range, 1'b1, {1'b0, cnt_r} <= (PW+1)'(NODES))
  `IMHQ_ASSERT_NXT(a_done_valid, state_r == S_DONE, ov_r)
  `IMHQ_ASSERT_IMP(a_no_accept_clr, clr_r, !in_ready)
endmodule
